// File: src/assert_macros.svh
// Assertion macros shared by the deframer RTL.
// Each macro samples on clk; the reset-qualified forms expect rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every rising edge of clk outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check prop on every rising edge of clk, reset included.
`define ASSERT_CLK_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_CLK_ALWAYS(label, prop, msg)
`endif

`endif

// File: src/mfd_pkg.sv
// Package for the marker frame deframer: parse phases, status codes, result type.
// No dependencies; used by the interfaces, the parser and the top level.
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam logic [BYTE_W-1:0] MARKER_RESET = 8'd62;

  typedef logic [BYTE_W-1:0] byte_t;

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_MARKER  = 3'd1,
    PH_ID      = 3'd2,
    PH_LEN     = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_CHECK   = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    ST_INCOMPLETE = 2'd0,
    ST_COMPLETE   = 2'd1,
    ST_ERROR      = 2'd2
  } status_t;

  typedef struct packed {
    status_t status;
    logic    payload_valid;
    byte_t   payload_byte;
    byte_t   payload_index;
    byte_t   frame_id;
    byte_t   frame_length;
  } res_t;

endpackage

// File: src/mfd_if.sv
// Valid/ready channel interfaces for the deframer: byte input, result output,
// and the start-marker configuration write. Depends on mfd_pkg.
`timescale 1ns / 1ps

interface mfd_in_if import mfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface mfd_out_if import mfd_pkg::*; ();
  logic    valid;
  logic    ready;
  logic [1:0] status;
  logic    payload_valid;
  byte_t   payload_byte;
  byte_t   payload_index;
  byte_t   frame_id;
  byte_t   frame_length;

  modport source (output valid, output status, output payload_valid, output payload_byte,
                  output payload_index, output frame_id, output frame_length, input ready);
  modport sink   (input valid, input status, input payload_valid, input payload_byte,
                  input payload_index, input frame_id, input frame_length, output ready);
endinterface

interface mfd_cfg_if import mfd_pkg::*; ();
  logic  valid;
  logic  ready;
  byte_t start_marker;

  modport source (output valid, output start_marker, input ready);
  modport sink   (input valid, input start_marker, output ready);
endinterface

// File: src/mfd_parser.sv
// Frame parser state machine: holds phase, id, length, payload count and running sum,
// and produces the result of one byte per step. Depends on mfd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mfd_parser import mfd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  step,
  input  byte_t in_byte,
  input  byte_t start_marker,
  output res_t  res
);

  phase_t phase_r, phase_nxt;
  byte_t  id_r, id_nxt;
  byte_t  len_r, len_nxt;
  byte_t  cnt_r, cnt_nxt;
  byte_t  sum_r, sum_nxt;
  byte_t  hdr_sum;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      id_r    <= '0;
      len_r   <= '0;
      cnt_r   <= '0;
      sum_r   <= '0;
    end else if (step) begin
      phase_r <= phase_nxt;
      id_r    <= id_nxt;
      len_r   <= len_nxt;
      cnt_r   <= cnt_nxt;
      sum_r   <= sum_nxt;
    end
  end

  assign hdr_sum = id_r + len_r;

  always_comb begin
    phase_nxt         = phase_r;
    id_nxt            = id_r;
    len_nxt           = len_r;
    cnt_nxt           = cnt_r;
    sum_nxt           = sum_r;
    res.status        = ST_INCOMPLETE;
    res.payload_valid = 1'b0;
    res.payload_byte  = '0;
    res.payload_index = '0;
    unique case (phase_r)
      PH_IDLE: begin
        if (in_byte == start_marker) begin
          // restart index and sum at every marker
          phase_nxt = PH_MARKER;
          cnt_nxt   = '0;
          sum_nxt   = '0;
        end else begin
          phase_nxt  = PH_IDLE;
          len_nxt    = '0;
          cnt_nxt    = '0;
          res.status = ST_ERROR;
        end
      end
      PH_MARKER: begin
        id_nxt    = in_byte;
        phase_nxt = PH_ID;
      end
      PH_ID: begin
        len_nxt   = in_byte;
        phase_nxt = PH_LEN;
      end
      PH_LEN: begin
        if (in_byte == hdr_sum) begin
          // empty payload goes straight to the sum check
          phase_nxt = (len_r == '0) ? PH_CHECK : PH_PAYLOAD;
        end else begin
          phase_nxt  = PH_IDLE;
          len_nxt    = '0;
          cnt_nxt    = '0;
          res.status = ST_ERROR;
        end
      end
      PH_PAYLOAD: begin
        res.payload_valid = 1'b1;
        res.payload_byte  = in_byte;
        res.payload_index = cnt_r;
        sum_nxt           = sum_r + in_byte;
        cnt_nxt           = cnt_r + 8'd1;
        if (cnt_nxt == len_r) begin
          phase_nxt = PH_CHECK;
        end
      end
      PH_CHECK: begin
        if (in_byte == sum_r) begin
          phase_nxt  = PH_IDLE;
          res.status = ST_COMPLETE;
        end else begin
          phase_nxt  = PH_IDLE;
          len_nxt    = '0;
          cnt_nxt    = '0;
          res.status = ST_ERROR;
        end
      end
      default: begin
        phase_nxt  = PH_IDLE;
        len_nxt    = '0;
        cnt_nxt    = '0;
        res.status = ST_ERROR;
      end
    endcase
    res.frame_id     = id_nxt;
    res.frame_length = len_nxt;
  end

  `ASSERT_CLK(a_payload_len_nonzero, (phase_r == PH_PAYLOAD) |-> (len_r != '0),
              "payload phase entered with zero length")
  `ASSERT_CLK(a_payload_cnt_bound, (phase_r == PH_PAYLOAD) |-> (cnt_r < len_r),
              "payload count reached declared length inside payload phase")
  `ASSERT_CLK(a_complete_to_idle, (step && res.status == ST_COMPLETE) |=> (phase_r == PH_IDLE),
              "parser not idle after complete frame")
  `ASSERT_CLK(a_error_clears, (step && res.status == ST_ERROR) |=>
              (phase_r == PH_IDLE && len_r == '0 && cnt_r == '0),
              "parser not cleared after error")

endmodule

// File: src/marker_frame_deframer.sv
// Marker frame deframer top level: byte input register, parser, result register,
// start-marker configuration register. Depends on mfd_pkg, mfd_if and mfd_parser.
//
// Usage:
//   in_ch  takes one received byte per transaction (valid/ready).
//   out_ch gives one result per byte: status (0 incomplete, 1 frame complete,
//          2 error), the payload byte with its index when the byte was payload,
//          and the current frame id and length.
//   cfg_ch writes the start marker byte; it is always ready. Write it only while
//          no byte is in flight.
// Path: a byte accepted into the input register steps the parser from there, and its
// result is loaded into the result register, which offers it on out_ch.
// Throughput: one byte per cycle while out_ch is not held; the parser state is one small update per byte.
// Reset (rst_n low, synchronous): parser idle, id/length/count/sum zero,
// start marker 62 ('>'), both pipeline registers empty.
// Stall: while out_ch is held, the result register and the input register hold,
// so up to two bytes are buffered; in_ch ready drops only when both are full.
`timescale 1ns / 1ps

module marker_frame_deframer import mfd_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  mfd_in_if.sink       in_ch,
  mfd_out_if.source    out_ch,
  mfd_cfg_if.sink      cfg_ch
);

  byte_t start_marker_r;
  logic  s1_valid_r, s1_valid_nxt;
  byte_t s1_byte_r;
  logic  out_valid_r, out_valid_nxt;
  res_t  out_res_r;
  res_t  step_res;
  logic  out_take;
  logic  step;
  logic  in_take;

  // result register can load when empty or drained this cycle
  assign out_take = !out_valid_r || out_ch.ready;
  assign step     = s1_valid_r && out_take;
  assign in_take  = in_ch.valid && in_ch.ready;

  assign in_ch.ready  = !s1_valid_r || out_take;
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_ch.ready) begin
      s1_valid_nxt = in_ch.valid;
    end
    out_valid_nxt = out_valid_r;
    if (out_take) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_marker_r <= MARKER_RESET;
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        start_marker_r <= cfg_ch.start_marker;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_ch.in_byte;
    end
    if (step) begin
      out_res_r <= step_res;
    end
  end

  mfd_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .step         (step),
    .in_byte      (s1_byte_r),
    .start_marker (start_marker_r),
    .res          (step_res)
  );

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.payload_valid = out_res_r.payload_valid;
  assign out_ch.payload_byte  = out_res_r.payload_byte;
  assign out_ch.payload_index = out_res_r.payload_index;
  assign out_ch.frame_id      = out_res_r.frame_id;
  assign out_ch.frame_length  = out_res_r.frame_length;

endmodule
